// File: design/lla_pkg.sv
// Package for the life-like automaton step block.
// Holds shared constants, the config register codes and the queue entry flags.
// No dependencies.
`default_nettype none

package lla_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 4096;

  localparam int RULE_BITS   = 9;
  localparam int WINDOW_BITS = 9;
  localparam int CENTRE_BIT  = 4;
  localparam int COUNT_W     = 4;

  localparam int ROWS_REG_W  = 13;
  localparam int COLS_REG_W  = 11;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int GEOM_MIN    = 3;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [RULE_BITS-1:0]  SURVIVE_RESET = 9'd66;
  localparam logic [RULE_BITS-1:0]  BIRTH_RESET   = 9'd1;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET    = 13'd10;
  localparam logic [COLS_REG_W-1:0] COLS_RESET    = 11'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SURVIVE = 2'd0,
    CFG_BIRTH   = 2'd1,
    CFG_ROWS    = 2'd2,
    CFG_COLS    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic alive;  // incoming cell
    logic emit;   // window centre is an interior cell
    logic last;   // centre is the final interior cell
  } cell_info_t;

  localparam int INFO_W = $bits(cell_info_t);

endpackage

`default_nettype wire

// File: design/lla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lla_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/lla_front.sv
// Front end: accepts cells, tracks the raster position and tags each word.
// Depends on lla_pkg.
`default_nettype none

module lla_front #(
  parameter int MAX_COLUMNS = lla_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = lla_pkg::MAX_ROWS_DEF,
  localparam int COL_W = $clog2(MAX_COLUMNS),
  localparam int ROW_W = $clog2(MAX_ROWS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cell_valid,
  input  wire logic             cell_alive,
  output logic                  cell_stall,
  input  wire logic             restart,
  input  wire logic [ROW_W-1:0] rows_last,
  input  wire logic [COL_W-1:0] cols_last,
  input  wire logic             q_full,
  output logic                  push,
  output lla_pkg::cell_info_t   push_info,
  output logic      [COL_W-1:0] push_col
);

  import lla_pkg::*;

  logic [ROW_W-1:0] row_pos, row_pos_next;
  logic [COL_W-1:0] col_pos, col_pos_next;
  logic             accept;
  logic             row_at_last, col_at_last;

  assign cell_stall  = q_full;
  assign accept      = cell_valid && !q_full;
  assign row_at_last = (row_pos == rows_last);
  assign col_at_last = (col_pos == cols_last);

  always_comb begin
    push_info.alive = cell_alive;
    push_info.emit  = (row_pos >= ROW_W'(2)) && (col_pos >= COL_W'(2));
    push_info.last  = row_at_last && col_at_last;
  end

  assign push     = accept;
  assign push_col = col_pos;

  always_comb begin
    row_pos_next = row_pos;
    col_pos_next = col_pos;
    if (accept) begin
      if (col_at_last) begin
        col_pos_next = '0;
        row_pos_next = row_at_last ? '0 : row_pos + ROW_W'(1);
      end else begin
        col_pos_next = col_pos + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_pos <= '0;
      col_pos <= '0;
    end else begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // last interior cell always sits inside the border
  a_last_is_interior: assert property (@(posedge clk) disable iff (rst)
    push && push_info.last |-> push_info.emit)
    else $error("last flag on a non-interior cell");

  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    (row_pos <= rows_last) && (col_pos <= cols_last))
    else $error("raster position outside the grid");

endmodule

`default_nettype wire

// File: design/lla_queue.sv
// Short FIFO between front and back ends.
// Depends on lla_pkg for the default depth.
`default_nettype none

module lla_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lla_pkg::QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop) && !(pop && empty))
    else $error("queue overflow or underflow");

endmodule

`default_nettype wire

// File: design/lla_back.sv
// Back end: line store, 3x3 window, neighbour count and rule lookup.
// Depends on lla_pkg and lla_ram.
`default_nettype none

module lla_back #(
  parameter int MAX_COLUMNS = lla_pkg::MAX_COLUMNS_DEF,
  localparam int COL_W = $clog2(MAX_COLUMNS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire lla_pkg::cell_info_t           q_info,
  input  wire logic [COL_W-1:0]              q_col,
  output logic                               pop,
  input  wire logic [lla_pkg::RULE_BITS-1:0] survive_mask,
  input  wire logic [lla_pkg::RULE_BITS-1:0] birth_mask,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic                               next_alive,
  output logic                               last_cell
);

  import lla_pkg::*;

  function automatic logic [COUNT_W-1:0] neighbour_count(input logic [WINDOW_BITS-1:0] w);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < WINDOW_BITS; k++) begin
      if (k != CENTRE_BIT) begin
        n = n + COUNT_W'(w[k]);
      end
    end
    return n;
  endfunction

  logic                   b_valid;
  cell_info_t             b_info;
  logic [COL_W-1:0]       b_col;
  logic [WINDOW_BITS-1:0] window, window_next;
  logic [1:0]             line_rd;   // [1] upper row, [0] middle row
  logic                   out_free, b_go;
  logic [COUNT_W-1:0]     count;
  logic [RULE_BITS-1:0]   rule;
  logic                   new_state;

  assign out_free = !result_valid || !result_stall;
  assign b_go     = b_valid && (!b_info.emit || out_free);
  assign pop      = !q_empty && (!b_valid || b_go);

  // read data holds while the stage is stalled since rd_en follows pop
  lla_ram #(
    .WIDTH (2),
    .DEPTH (MAX_COLUMNS)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (b_go),
    .wr_addr (b_col),
    .wr_data ({line_rd[0], b_info.alive}),
    .rd_en   (pop),
    .rd_addr (q_col),
    .rd_data (line_rd)
  );

  assign window_next = {window[WINDOW_BITS-4:0], line_rd[1], line_rd[0], b_info.alive};
  assign count       = neighbour_count(window_next);
  assign rule        = window_next[CENTRE_BIT] ? survive_mask : birth_mask;
  assign new_state   = rule[count];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_info <= q_info;
      b_col  <= q_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (b_go) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_go && b_info.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_info.emit) begin
      next_alive <= new_state;
      last_cell  <= b_info.last;
    end
  end

  a_emit_loads_result: assert property (@(posedge clk) disable iff (rst)
    b_go && b_info.emit |=> result_valid)
    else $error("interior cell left no result word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_info.emit && result_valid && result_stall |-> !b_go)
    else $error("pending result word overwritten");

endmodule

`default_nettype wire

// File: design/life_like_automaton_step_top.sv
// Life-like automaton step: one cell in per unstalled cycle, one result word per interior cell.
// Path from the window's lower right cell: queue, back end cell register, result register.
// Throughput: 1 cell per cycle when not stalled, set by the line store's one read/write pair.
// Sync reset clears positions, queue, window and result valid, and loads the register defaults.
// Line store contents are not cleared: each entry is rewritten in the first two rows of a grid.
// Depends on lla_pkg, lla_front, lla_queue, lla_back, lla_ram.
`default_nettype none

module life_like_automaton_step_top #(
  parameter int MAX_COLUMNS = lla_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = lla_pkg::MAX_ROWS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [lla_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lla_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            cell_valid,
  output logic                                 cell_stall,
  input  wire logic                            cell_alive,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic                                 next_alive,
  output logic                                 last_cell
);

  import lla_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int Q_W   = INFO_W + COL_W;

  logic [RULE_BITS-1:0]  survive_mask, birth_mask;
  logic [ROWS_REG_W-1:0] row_count;
  logic [COLS_REG_W-1:0] column_count;
  logic                  restart;
  logic [31:0]           rows_eff, cols_eff;
  logic [ROW_W-1:0]      rows_last;
  logic [COL_W-1:0]      cols_last;

  logic             q_push, q_pop, q_full, q_empty;
  cell_info_t       push_info, pop_info;
  logic [COL_W-1:0] push_col, pop_col;
  logic [Q_W-1:0]   q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      survive_mask <= SURVIVE_RESET;
      birth_mask   <= BIRTH_RESET;
      row_count    <= ROWS_RESET;
      column_count <= COLS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SURVIVE: survive_mask <= cfg_data[RULE_BITS-1:0];
        CFG_BIRTH:   birth_mask   <= cfg_data[RULE_BITS-1:0];
        CFG_ROWS:    row_count    <= cfg_data[ROWS_REG_W-1:0];
        CFG_COLS:    column_count <= cfg_data[COLS_REG_W-1:0];
      endcase
    end
  end

  // geometry writes send the raster back to the top left
  assign restart = cfg_write &&
                   ((cfg_reg_t'(cfg_index) == CFG_ROWS) || (cfg_reg_t'(cfg_index) == CFG_COLS));

  always_comb begin
    rows_eff = 32'(row_count);
    if (rows_eff < 32'(GEOM_MIN)) begin
      rows_eff = 32'(GEOM_MIN);
    end else if (rows_eff > 32'(MAX_ROWS)) begin
      rows_eff = 32'(MAX_ROWS);
    end
    cols_eff = 32'(column_count);
    if (cols_eff < 32'(GEOM_MIN)) begin
      cols_eff = 32'(GEOM_MIN);
    end else if (cols_eff > 32'(MAX_COLUMNS)) begin
      cols_eff = 32'(MAX_COLUMNS);
    end
  end

  assign rows_last = ROW_W'(rows_eff - 32'd1);
  assign cols_last = COL_W'(cols_eff - 32'd1);

  lla_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_alive (cell_alive),
    .cell_stall (cell_stall),
    .restart    (restart),
    .rows_last  (rows_last),
    .cols_last  (cols_last),
    .q_full     (q_full),
    .push       (q_push),
    .push_info  (push_info),
    .push_col   (push_col)
  );

  assign q_in = {push_info, push_col};

  lla_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign pop_info = cell_info_t'(q_out[Q_W-1:COL_W]);
  assign pop_col  = q_out[COL_W-1:0];

  lla_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_info       (pop_info),
    .q_col        (pop_col),
    .pop          (q_pop),
    .survive_mask (survive_mask),
    .birth_mask   (birth_mask),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .next_alive   (next_alive),
    .last_cell    (last_cell)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for life_like_automaton_step_top: streams cell words in raster order
// and checks every next-generation word against a built-in line-store and window predictor.
// Depends on lla_pkg and the design under design/.
`timescale 1ns / 1ps

module tb_top;
  import lla_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 1000;
  localparam int RANDOM_CELLS  = 650;

  typedef struct packed {
    logic next_alive;
    logic last_cell;
  } gen_result_t;

  typedef enum logic [1:0] {
    DIR_CONFIG,
    DIR_CELLS,
    DIR_GRID
  } dir_kind_t;

  // value: register data, cell count, or a 3x3 grid in raster order (bit 0 first)
  typedef struct packed {
    dir_kind_t            kind;
    cfg_reg_t             sel;
    logic [CFG_DATA_W-1:0] value;
    logic                 alive;
    gen_result_t          want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [0:6] = '{
    // reset geometry is 10x10: first word is for the dead centre (1,1), birth on 0 neighbors
    {DIR_CELLS,  CFG_SURVIVE, 13'd23,    1'b0, 2'b10},
    // geometry writes restart the grid mid-way; zero clamps to 3x3
    {DIR_CONFIG, CFG_ROWS,    13'd0,     1'b0, 2'b00},
    {DIR_CONFIG, CFG_COLS,    13'd0,     1'b0, 2'b00},
    {DIR_CONFIG, CFG_SURVIVE, 13'h1F00,  1'b0, 2'b00},
    {DIR_CONFIG, CFG_BIRTH,   13'h1E00,  1'b0, 2'b00},
    // all live, border included: survives on 8 neighbors
    {DIR_GRID,   CFG_SURVIVE, 13'h01FF,  1'b0, 2'b11},
    // grid wraps straight into the next one; all dead, no birth rule bits
    {DIR_GRID,   CFG_SURVIVE, 13'h0000,  1'b0, 2'b01}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   cell_valid = 1'b0;
  logic                   cell_stall;
  logic                   cell_alive = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   next_alive;
  logic                   last_cell;

  // predictor state
  bit                    upper_row_bits [MAX_COLUMNS_DEF];
  bit                    middle_row_bits [MAX_COLUMNS_DEF];
  logic [WINDOW_BITS-1:0] window_bits = '0;
  int unsigned           row_pos = 0;
  int unsigned           col_pos = 0;
  logic [RULE_BITS-1:0]  survive_rule = SURVIVE_RESET;
  logic [RULE_BITS-1:0]  birth_rule = BIRTH_RESET;
  logic [ROWS_REG_W-1:0] rows_reg = ROWS_RESET;
  logic [COLS_REG_W-1:0] cols_reg = COLS_RESET;

  gen_result_t next_states_due [$];
  int          error_count = 0;
  int          quiet_cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  life_like_automaton_step_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_alive   (cell_alive),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .next_alive   (next_alive),
    .last_cell    (last_cell)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned effective_rows();
    if (rows_reg < GEOM_MIN) return GEOM_MIN;
    if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return rows_reg;
  endfunction

  function automatic int unsigned effective_cols();
    if (cols_reg < GEOM_MIN) return GEOM_MIN;
    if (cols_reg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return cols_reg;
  endfunction

  // Shift one cell into the line stores and window; returns 1 when an interior word is due.
  function automatic bit evolve_cell(input bit alive, output gen_result_t res);
    int unsigned rows;
    int unsigned cols;
    int unsigned neighbors;
    bit          top;
    bit          mid;
    rows = effective_rows();
    cols = effective_cols();
    top = upper_row_bits[col_pos];
    mid = middle_row_bits[col_pos];
    upper_row_bits[col_pos] = mid;
    middle_row_bits[col_pos] = alive;
    window_bits = {window_bits[5:0], top, mid, alive};
    res = '0;
    evolve_cell = 1'b0;
    if (row_pos >= 2 && col_pos >= 2) begin
      neighbors = $countones(window_bits) - window_bits[CENTRE_BIT];
      res.next_alive = window_bits[CENTRE_BIT] ? survive_rule[neighbors] : birth_rule[neighbors];
      res.last_cell = (row_pos + 1 >= rows) && (col_pos + 1 >= cols);
      evolve_cell = 1'b1;
    end
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rule_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CFG_DATA_W'($urandom_range(0, 8191));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic write_register(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (sel)
      CFG_SURVIVE: survive_rule = value[RULE_BITS-1:0];
      CFG_BIRTH:   birth_rule = value[RULE_BITS-1:0];
      CFG_ROWS: begin
        rows_reg = value[ROWS_REG_W-1:0];
        row_pos = 0;
        col_pos = 0;
      end
      default: begin
        cols_reg = value[COLS_REG_W-1:0];
        row_pos = 0;
        col_pos = 0;
      end
    endcase
  endtask

  task automatic drain_results();
    cell_valid <= 1'b0;
    @(posedge clk);
    while (next_states_due.size() != 0) @(posedge clk);
  endtask

  // border words give no result, so let the pipeline empty before touching registers
  task automatic settle_for_config();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_cell(input bit alive, input bit typed, input gen_result_t typed_res);
    gen_result_t predicted;
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_alive <= alive;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    if (evolve_cell(alive, predicted)) next_states_due.push_back(typed ? typed_res : predicted);
  endtask

  always @(posedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : result_check
    gen_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (next_states_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word next_alive=%0b last_cell=%0b",
                                  next_alive, last_cell));
      end else begin
        want = next_states_due.pop_front();
        if (next_alive !== want.next_alive)
          report_mismatch($sformatf("next_alive got %0b want %0b", next_alive, want.next_alive));
        if (last_cell !== want.last_cell)
          report_mismatch($sformatf("last_cell got %0b want %0b", last_cell, want.last_cell));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cell_valid && !cell_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    int       n;
    int       phase;
    int       random_cells;
    int       total;
    int       pause_at;
    int       density;
    bit       well_formed;
    bit       alive;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      case (row.kind)
        DIR_CONFIG: begin
          settle_for_config();
          write_register(row.sel, row.value);
        end
        DIR_CELLS: for (n = 0; n < int'(row.value); n++) send_cell(row.alive, 1'b1, row.want);
        default:   for (n = 0; n < 9; n++) send_cell(row.value[n], 1'b1, row.want);
      endcase
    end

    phase = 0;
    random_cells = 0;
    while (phase < 8 || random_cells < RANDOM_CELLS) begin
      case ((phase / 2) % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 52; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 15; stall_pct = 15; end
      endcase
      settle_for_config();
      if ($urandom_range(0, 1) != 0) write_register(CFG_SURVIVE, pick_rule_value());
      if ($urandom_range(0, 1) != 0) write_register(CFG_BIRTH, pick_rule_value());
      total = 0;
      // odd early phases take the geometry extremes over a partial grid; the rest are small grids
      case (phase)
        1: begin
          write_register(CFG_ROWS, 13'd3);
          write_register(CFG_COLS, 13'd1024);
          total = 60;
        end
        3: begin
          // row count clamps to the maximum, column bits above the register drop off
          write_register(CFG_ROWS, 13'h1FFF);
          write_register(CFG_COLS, 13'h1803);
          total = 60;
        end
        5: begin
          write_register(CFG_ROWS, 13'd4096);
          write_register(CFG_COLS, 13'd3);
          total = 60;
        end
        7: begin
          write_register(CFG_ROWS, 13'd0);
          write_register(CFG_COLS, 13'h07FF);
          total = 60;
        end
        default: begin
          if (effective_rows() * effective_cols() > 90 || $urandom_range(0, 3) != 0) begin
            write_register(CFG_ROWS, 13'($urandom_range(0, 8)));
            write_register(CFG_COLS, 13'($urandom_range(0, 10)));
          end
          total = int'($urandom_range(1, 3)) * effective_rows() * effective_cols();
          if ($urandom_range(0, 3) == 0) total += int'($urandom_range(1, 2 * effective_cols()));
        end
      endcase
      if (total == 0) total = effective_rows() * effective_cols();
      random_cells += total;

      density = $urandom_range(0, 100);
      well_formed = ($urandom_range(0, 3) != 0);
      pause_at = (phase == 2 || $urandom_range(0, 2) == 0) ? int'($urandom_range(0, total - 1)) : -1;
      for (n = 0; n < total; n++) begin
        if (n == pause_at) drain_results();
        if (well_formed && (row_pos == 0 || row_pos + 1 == effective_rows() ||
                            col_pos == 0 || col_pos + 1 == effective_cols()))
          alive = 1'b0;
        else
          alive = ($urandom_range(0, 99) < density);
        send_cell(alive, 1'b0, '0);
      end
      phase++;
    end

    drain_results();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && next_states_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
